/* rtl/i2cmra_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types and constants for the i2c master register access block.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // op codes of a command item
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // slot length after reset, in ticks
  localparam logic [15:0] SLOT_TICKS_RESET = 16'd5;

  // bus phases, one delay slot each except idle
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_A  = 5'd1,
    PH_START_B  = 5'd2,
    PH_START_C  = 5'd3,
    PH_TX_PRE   = 5'd4,
    PH_TX_SET   = 5'd5,
    PH_TX_HIGH  = 5'd6,
    PH_TX_LOW   = 5'd7,
    PH_ACK_HIGH = 5'd8,
    PH_ACK_LOW  = 5'd9,
    PH_RX_LOW   = 5'd10,
    PH_RX_HIGH  = 5'd11,
    PH_MACK_A   = 5'd12,
    PH_MACK_B   = 5'd13,
    PH_STOP_PRE = 5'd14,
    PH_STOP_A   = 5'd15,
    PH_STOP_B   = 5'd16
  } phase_t;

  // which byte of the transaction is on the bus
  typedef enum logic [2:0] {
    ST_ADDR_W = 3'd0,
    ST_REG    = 3'd1,
    ST_DATA_W = 3'd2,
    ST_ADDR_R = 3'd3,
    ST_DATA_R = 3'd4
  } stage_t;

  // one tick of input
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } cmd_t;

  // one tick of bus drive and status
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       write_taken;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic       status;
  } rsp_t;

endpackage

/* rtl/i2cmra_core.sv */
// ----------------------------------------------------------------------------
// i2cmra_core
// Bus phase sequencer: advances the transaction state by one tick per step
// and produces that tick's bus levels and status.
// ----------------------------------------------------------------------------
module i2cmra_core import i2cmra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  cmd_t        item,
  input  logic [15:0] slot_ticks,
  output rsp_t        res
);

  phase_t      phase, phase_next, act_phase;
  stage_t      stage, stage_next;
  logic [15:0] slot_timer, slot_timer_next, timer_cur, slot_len;
  logic [3:0]  bit_position, bit_position_next, rx_pos;
  logic [7:0]  shifter, shifter_next, rx_shift;
  logic [7:0]  bytes_left, bytes_left_next, bytes_dec;
  logic [6:0]  target_device, target_device_next;
  logic [7:0]  target_register, target_register_next;
  logic        read_mode, read_mode_next;
  logic        nack_seen, nack_seen_next;
  logic        failed, failed_next;
  logic        tx_bit, mack, slot_end;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      stage           <= ST_ADDR_W;
      slot_timer      <= '0;
      bit_position    <= '0;
      shifter         <= '0;
      bytes_left      <= '0;
      target_device   <= '0;
      target_register <= '0;
      read_mode       <= 1'b0;
      nack_seen       <= 1'b0;
      failed          <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      stage           <= stage_next;
      slot_timer      <= slot_timer_next;
      bit_position    <= bit_position_next;
      shifter         <= shifter_next;
      bytes_left      <= bytes_left_next;
      target_device   <= target_device_next;
      target_register <= target_register_next;
      read_mode       <= read_mode_next;
      nack_seen       <= nack_seen_next;
      failed          <= failed_next;
    end
  end

  // helpers from the current state
  assign slot_len  = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
  assign tx_bit    = shifter[bit_position[2:0]];
  assign mack      = (bytes_left == 8'd1);
  assign bytes_dec = bytes_left - 8'd1;
  assign rx_shift  = {shifter[6:0], item.sda_in};
  assign rx_pos    = bit_position + 4'd1;

  // next state and tick outputs
  always_comb begin
    phase_next           = phase;
    stage_next           = stage;
    slot_timer_next      = slot_timer;
    bit_position_next    = bit_position;
    shifter_next         = shifter;
    bytes_left_next      = bytes_left;
    target_device_next   = target_device;
    target_register_next = target_register;
    read_mode_next       = read_mode;
    nack_seen_next       = nack_seen;
    failed_next          = failed;
    act_phase            = phase;
    timer_cur            = slot_timer;
    slot_end             = 1'b0;
    res                  = '0;
    res.scl              = 1'b1;
    res.sda_out          = 1'b1;
    res.sda_drive        = 1'b1;
    res.busy_res         = 1'b1;

    // idle: take a new transaction
    if (phase == PH_IDLE || phase > PH_STOP_B) begin
      act_phase  = PH_IDLE;
      phase_next = PH_IDLE;
      if (item.op == OP_WRITE || item.op == OP_READ) begin
        read_mode_next       = (item.op == OP_READ);
        target_device_next   = item.device_address;
        target_register_next = item.register_address;
        bytes_left_next      = item.byte_count;
        stage_next           = ST_ADDR_W;
        failed_next          = 1'b0;
        nack_seen_next       = 1'b0;
        timer_cur            = '0;
        slot_timer_next      = '0;
        act_phase            = PH_START_A;
        phase_next           = PH_START_A;
      end
    end

    // bus levels of the active slot
    case (act_phase)
      PH_START_A: begin
        res.scl = 1'b1; res.sda_out = 1'b1;
      end
      PH_START_B, PH_STOP_A: begin
        res.scl = 1'b1; res.sda_out = 1'b0;
      end
      PH_START_C, PH_TX_PRE, PH_STOP_PRE: begin
        res.scl = 1'b0; res.sda_out = 1'b0;
      end
      PH_TX_SET, PH_TX_LOW: begin
        res.scl = 1'b0; res.sda_out = tx_bit;
      end
      PH_TX_HIGH: begin
        res.scl = 1'b1; res.sda_out = tx_bit;
      end
      PH_ACK_HIGH, PH_RX_HIGH: begin
        res.scl = 1'b1; res.sda_drive = 1'b0;
      end
      PH_ACK_LOW, PH_RX_LOW: begin
        res.scl = 1'b0; res.sda_drive = 1'b0;
      end
      PH_MACK_A: begin
        res.scl = 1'b0; res.sda_out = mack;
      end
      PH_MACK_B: begin
        res.scl = 1'b1; res.sda_out = mack;
      end
      PH_STOP_B: begin
        res.scl = 1'b1; res.sda_out = 1'b1;
      end
      default: begin
        res.busy_res = 1'b0;
      end
    endcase

    // slot timer
    if (act_phase != PH_IDLE) begin
      if (({1'b0, timer_cur} + 17'd1) < {1'b0, slot_len}) begin
        slot_timer_next = timer_cur + 16'd1;
      end else begin
        slot_timer_next = '0;
        slot_end        = 1'b1;
      end
    end

    // phase transitions at the end of a slot
    if (slot_end) begin
      case (act_phase)
        PH_START_A: phase_next = PH_START_B;
        PH_START_B: phase_next = PH_START_C;
        PH_START_C: begin
          if (stage == ST_ADDR_R) begin
            shifter_next = {target_device, 1'b1};
            stage_next   = ST_ADDR_R;
          end else begin
            shifter_next = {target_device, 1'b0};
            stage_next   = ST_ADDR_W;
          end
          bit_position_next = 4'd7;
          phase_next        = PH_TX_PRE;
        end
        PH_TX_PRE:  phase_next = PH_TX_SET;
        PH_TX_SET:  phase_next = PH_TX_HIGH;
        PH_TX_HIGH: phase_next = PH_TX_LOW;
        PH_TX_LOW: begin
          if (bit_position[2:0] == 3'd0) begin
            phase_next = PH_ACK_HIGH;
          end else begin
            bit_position_next = {1'b0, bit_position[2:0] - 3'd1};
            phase_next        = PH_TX_SET;
          end
        end
        PH_ACK_HIGH: begin
          nack_seen_next = item.sda_in;
          phase_next     = PH_ACK_LOW;
        end
        PH_ACK_LOW: begin
          case (stage)
            ST_ADDR_W: begin
              if (nack_seen) begin
                failed_next = 1'b1;
                phase_next  = PH_STOP_PRE;
              end else begin
                shifter_next      = target_register;
                stage_next        = ST_REG;
                bit_position_next = 4'd7;
                phase_next        = PH_TX_PRE;
              end
            end
            ST_REG, ST_DATA_W: begin
              if (stage == ST_REG && read_mode) begin
                // repeated start for the read address
                stage_next = ST_ADDR_R;
                phase_next = PH_START_A;
              end else if (stage == ST_DATA_W && nack_seen) begin
                failed_next = 1'b1;
                phase_next  = PH_STOP_PRE;
              end else if (bytes_left == 8'd0) begin
                failed_next = 1'b0;
                phase_next  = PH_STOP_PRE;
              end else begin
                // fetch the next data byte
                res.write_taken   = 1'b1;
                bytes_left_next   = bytes_dec;
                shifter_next      = item.write_byte;
                stage_next        = ST_DATA_W;
                bit_position_next = 4'd7;
                phase_next        = PH_TX_PRE;
              end
            end
            default: begin
              if (nack_seen) begin
                failed_next = 1'b1;
                phase_next  = PH_STOP_PRE;
              end else if (bytes_left == 8'd0) begin
                failed_next = 1'b0;
                phase_next  = PH_STOP_PRE;
              end else begin
                shifter_next      = '0;
                bit_position_next = '0;
                stage_next        = ST_DATA_R;
                phase_next        = PH_RX_LOW;
              end
            end
          endcase
        end
        PH_RX_LOW: phase_next = PH_RX_HIGH;
        PH_RX_HIGH: begin
          shifter_next      = rx_shift;
          bit_position_next = rx_pos;
          if (rx_pos[3]) begin
            res.read_valid = 1'b1;
            res.read_data  = rx_shift;
            phase_next     = PH_MACK_A;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
        PH_MACK_A: phase_next = PH_MACK_B;
        PH_MACK_B: begin
          bytes_left_next = bytes_dec;
          if (bytes_dec == 8'd0) begin
            failed_next = 1'b0;
            phase_next  = PH_STOP_PRE;
          end else begin
            shifter_next      = '0;
            bit_position_next = '0;
            stage_next        = ST_DATA_R;
            phase_next        = PH_RX_LOW;
          end
        end
        PH_STOP_PRE: phase_next = PH_STOP_A;
        PH_STOP_A:   phase_next = PH_STOP_B;
        default: begin
          res.done_res = 1'b1;
          res.status   = failed;
          phase_next   = PH_IDLE;
        end
      endcase
    end

    // released line reads high
    if (!res.sda_drive) begin
      res.sda_out = 1'b1;
    end
  end

endmodule

/* rtl/i2c_master_register_access.sv */
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master running register write and read transactions, one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one item per bus tick, carrying
//   the op, addresses, byte count, the next write byte and the sampled SDA.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one item per cmd item,
//   with SCL, SDA drive, busy, write_taken, read data and done/status.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): slot length in ticks,
//   always ready; the user writes it only while no transaction is running.
// Path: a cmd item passes the input register, then the result register, before
//   its rsp item appears. Throughput: one item per cycle while no stall holds,
//   set by the single sequencer step between the two registers.
// Reset: bus sequencer idle, both registers empty, slot length 5 ticks.
// Stall: while rsp_stall holds a full result register, the input register
//   keeps its item and cmd_stall rises once it is full as well; the bus
//   sequencer advances only when a tick moves into the result register.
// ----------------------------------------------------------------------------
module i2c_master_register_access import i2cmra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        in_full;
  cmd_t        in_item;
  logic        advance;
  logic [15:0] slot_ticks;
  rsp_t        core_res;

  // stage handshakes
  assign advance   = in_full && (!rsp_valid || !rsp_stall);
  assign cmd_stall = in_full && !advance;
  assign cfg_ready = 1'b1;

  // slot length register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= SLOT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_item <= cmd;
    end
  end

  // bus sequencer
  i2cmra_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .slot_ticks (slot_ticks),
    .res        (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= core_res;
    end
  end

  // every tick taken by the sequencer shows up as a result item
  a_step_to_rsp : assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("sequencer step produced no result item");

  // input side holds off only when both registers are full and stalled
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (in_full && rsp_valid && rsp_stall))
    else $error("cmd stalled without a full pipeline");

  // byte handoff happens only in slots where the slave owns SDA
  a_handoff_released : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.read_valid || rsp.write_taken)) |-> !rsp.sda_drive)
    else $error("byte handoff while master drives SDA");

  // completion comes while busy and status only with completion
  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.done_res || rsp.status)) |-> (rsp.busy_res && rsp.done_res))
    else $error("done or status outside a finishing transaction");

endmodule
